[rtl/chassis_thermal_shutdown_supervisor_defines.svh]
// ----------------------------------------------------------------------------
// Thermal shutdown supervisor: assertion macros
// Shared concurrent assertion forms, clocked and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef CHASSIS_THERMAL_SHUTDOWN_SUPERVISOR_DEFINES_SVH
`define CHASSIS_THERMAL_SHUTDOWN_SUPERVISOR_DEFINES_SVH

// same-cycle implication
`define CTSS_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define CTSS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/ctss_pkg.sv]
// ----------------------------------------------------------------------------
// ctss_pkg
// Types, codes, card mapping helpers and the sequencer program.
// ----------------------------------------------------------------------------
package ctss_pkg;

  localparam int SENSOR_COUNT = 72;
  localparam int LINE_CARDS   = 8;
  localparam int ID_W         = 7;
  localparam int TEMP_W       = 18;
  localparam int CNT_W        = 5;
  localparam int ADDR_W       = $clog2(SENSOR_COUNT);
  localparam int CFG_IDX_W    = 2;
  localparam int CFG_DATA_W   = 5;
  localparam int PC_W         = 5;
  localparam int LC_W         = $clog2(LINE_CARDS);

  localparam logic [CNT_W-1:0] CNT_MAX = '1;

  // sensor id map
  localparam logic [ID_W-1:0] LC_LO_LAST   = 7'd24;
  localparam logic [ID_W-1:0] FC_A1_FIRST  = 7'd31;
  localparam logic [ID_W-1:0] FC_A1_LAST   = 7'd36;
  localparam logic [ID_W-1:0] LC_HI_FIRST  = 7'd37;
  localparam logic [ID_W-1:0] LC_HI_LAST   = 7'd60;
  localparam logic [ID_W-1:0] FC_B1_FIRST  = 7'd67;
  localparam logic [ID_W-1:0] ID_LAST      = 7'(SENSOR_COUNT);

  // read status codes
  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_ABSENT = 2'd1;
  localparam logic [1:0] ST_IO_ERR = 2'd2;

  typedef enum logic [2:0] {
    ACT_WARN      = 3'd0,
    ACT_LC_LOCAL  = 3'd1,
    ACT_LC_REMOTE = 3'd2,
    ACT_FC_OFF    = 3'd3,
    ACT_MAC_RESET = 3'd4,
    ACT_CPU_RESET = 3'd5
  } action_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ENABLE    = 2'd0,
    REG_OWN_SLOT  = 2'd1,
    REG_RETRY     = 2'd2,
    REG_SELF_OFF  = 2'd3
  } reg_idx_t;

  // sequencer step kind
  typedef enum logic [1:0] {
    Q_IDLE,
    Q_UPDATE,
    Q_NEXT,
    Q_FINISH
  } seq_t;

  // emit condition select
  typedef enum logic [2:0] {
    C_NEVER,
    C_WARN,
    C_LINE_HOT,
    C_FAB_NB,
    C_FAB_OWN,
    C_OTHERS,
    C_ITSELF
  } cond_t;

  // target select
  typedef enum logic [1:0] {
    T_SENSOR,
    T_LC,
    T_FC_NB,
    T_OWN_SLOT
  } tsel_t;

  typedef struct packed {
    seq_t            seq;
    cond_t           cond;
    tsel_t           tsel;
    action_t         act;
    logic [LC_W-1:0] lc;
    logic            unit;
    logic            cause;
  } ctrl_t;

  typedef struct packed {
    action_t         action;
    logic [ID_W-1:0] target;
    logic            unit;
    logic            cause;
  } res_t;

  // program labels
  localparam logic [PC_W-1:0] PC_IDLE   = 5'd0;
  localparam logic [PC_W-1:0] PC_UPD    = 5'd1;
  localparam logic [PC_W-1:0] PC_HOT_LC = 5'd2;
  localparam logic [PC_W-1:0] PC_FIN    = 5'd25;

  function automatic ctrl_t ucode(input logic [PC_W-1:0] pc);
    ctrl_t cw;
    logic [PC_W-1:0] ofs;
    cw  = '{seq: Q_NEXT, cond: C_NEVER, tsel: T_SENSOR, act: ACT_WARN,
            lc: '0, unit: 1'b0, cause: 1'b0};
    ofs = '0;
    case (pc) inside
      5'd0: cw.seq = Q_IDLE;
      5'd1: begin
        cw.seq  = Q_UPDATE;
        cw.cond = C_WARN;
      end
      [5'd2:5'd9]: begin
        ofs     = pc - PC_HOT_LC;
        cw.cond = C_LINE_HOT;
        cw.tsel = T_LC;
        cw.act  = ACT_LC_LOCAL;
        cw.lc   = ofs[LC_W-1:0];
      end
      5'd10: begin
        cw.cond = C_FAB_NB;
        cw.tsel = T_FC_NB;
        cw.act  = ACT_FC_OFF;
      end
      5'd11: begin
        cw.cond = C_FAB_OWN;
        cw.tsel = T_OWN_SLOT;
        cw.act  = ACT_FC_OFF;
      end
      [5'd12:5'd19]: begin
        ofs      = pc - 5'd12;
        cw.cond  = C_OTHERS;
        cw.tsel  = T_LC;
        cw.act   = ACT_LC_LOCAL;
        cw.lc    = ofs[LC_W-1:0];
        cw.cause = 1'b1;
      end
      5'd20: begin
        cw.cond  = C_OTHERS;
        cw.tsel  = T_FC_NB;
        cw.act   = ACT_FC_OFF;
        cw.cause = 1'b1;
      end
      5'd21, 5'd22: begin
        cw.cond  = C_OTHERS;
        cw.tsel  = T_OWN_SLOT;
        cw.act   = ACT_MAC_RESET;
        cw.unit  = pc[0] ^ 1'b1;
        cw.cause = 1'b1;
      end
      5'd23: begin
        cw.cond  = C_OTHERS;
        cw.tsel  = T_OWN_SLOT;
        cw.act   = ACT_CPU_RESET;
        cw.unit  = 1'b1;
        cw.cause = 1'b1;
      end
      5'd24: begin
        cw.cond  = C_ITSELF;
        cw.tsel  = T_OWN_SLOT;
        cw.act   = ACT_FC_OFF;
        cw.cause = 1'b1;
      end
      5'd25: cw.seq = Q_FINISH;
      default: cw.seq = Q_FINISH;
    endcase
    return cw;
  endfunction

  function automatic logic is_line(input logic [ID_W-1:0] id);
    return (id <= LC_LO_LAST) || (id >= LC_HI_FIRST && id <= LC_HI_LAST);
  endfunction

  // six sensors per line card, low half then high half
  function automatic logic [LC_W-1:0] lc_of(input logic [ID_W-1:0] id);
    logic [ID_W-1:0] v;
    logic [1:0]      grp;
    v   = (id <= LC_LO_LAST) ? id - 7'd1 : id - LC_HI_FIRST;
    grp = (v >= 7'd18) ? 2'd3 : (v >= 7'd12) ? 2'd2 : (v >= 7'd6) ? 2'd1 : 2'd0;
    return {id > LC_LO_LAST, grp};
  endfunction

  function automatic logic fab_idx_of(input logic [ID_W-1:0] id);
    return (id >= FC_A1_FIRST && id <= FC_A1_LAST) || (id >= FC_B1_FIRST);
  endfunction

endpackage

[rtl/ctss_if.sv]
// ----------------------------------------------------------------------------
// ctss_in_if / ctss_out_if
// Valid/ready channels for sensor readings and supervisor actions.
// ----------------------------------------------------------------------------
interface ctss_in_if;
  import ctss_pkg::*;

  logic                     valid;
  logic                     ready;
  logic [ID_W-1:0]          sensor_id;
  logic signed [TEMP_W-1:0] temperature;
  logic signed [TEMP_W-1:0] warn_level;
  logic signed [TEMP_W-1:0] trip_level;
  logic [1:0]               read_status;
  logic                     scan_end;

  modport source (output valid, sensor_id, temperature, warn_level, trip_level,
                  read_status, scan_end, input ready);
  modport sink   (input valid, sensor_id, temperature, warn_level, trip_level,
                  read_status, scan_end, output ready);
endinterface

interface ctss_out_if;
  import ctss_pkg::*;

  logic            valid;
  logic            ready;
  logic [2:0]      action;
  logic [ID_W-1:0] target;
  logic            unit;
  logic            cause;
  logic            run_end;

  modport source (output valid, action, target, unit, cause, run_end, input ready);
  modport sink   (input valid, action, target, unit, cause, run_end, output ready);
endinterface

[rtl/chassis_thermal_shutdown_supervisor.sv]
// ----------------------------------------------------------------------------
// chassis_thermal_shutdown_supervisor
// Per-reading thermal and io-error checks with warnings and end-of-scan
// shutdown and reset actions, run by a small microcoded sequencer.
// ----------------------------------------------------------------------------
//
//  channel | dir | handshake          | payload
//  --------+-----+--------------------+------------------------------------------
//  in_ch   | in  | valid/ready        | sensor_id, temperature, warn/trip, status,
//          |     |                    | scan_end
//  out_ch  | out | valid/ready        | action, target, unit, cause, run_end
//  cfg     | in  | cfg_we, no wait    | cfg_index, cfg_wdata
//
//  An item without scan_end goes through accept, update and finish; an item
//  closing a scan walks every program step. Disabled, an item is only accepted.
//  The program walks one action slot per cycle unless the output stalls.
//  Output stalls freeze the program on the step that needs to emit.
//  Reset is synchronous: counters read zero through per-entry valid bits,
//  per-scan flags clear, registers return to enable=1, slot 0, 2, 20.
//
module chassis_thermal_shutdown_supervisor (
  input  logic                             clk,
  input  logic                             rst_n,
  ctss_in_if.sink                          in_ch,
  ctss_out_if.source                       out_ch,
  input  logic                             cfg_we,
  input  logic [ctss_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [ctss_pkg::CFG_DATA_W-1:0]  cfg_wdata
);
  import ctss_pkg::*;

  // configuration
  logic             enable_r;
  logic [1:0]       own_slot_r;
  logic [CNT_W-1:0] retry_r;
  logic [CNT_W-1:0] self_off_r;

  // sequencer
  logic [PC_W-1:0] pc_r, pc_nxt;
  ctrl_t           cw;

  // captured item
  logic [ID_W-1:0]          id_r;
  logic signed [TEMP_W-1:0] temp_r, warn_r, trip_r;
  logic [1:0]               status_r;
  logic                     end_r;

  // error counter store
  logic [CNT_W-1:0]        cnt_mem [SENSOR_COUNT];
  logic [SENSOR_COUNT-1:0] cnt_vld_r;
  logic [CNT_W-1:0]        rd_cnt_r;
  logic [ADDR_W-1:0]       rd_addr, addr;
  logic                    mem_we;

  // per-scan flags
  logic [LINE_CARDS-1:0] line_hot_r, line_hot_nxt;
  logic [1:0]            fabric_hot_r, fabric_hot_nxt;
  logic                  off_others_r, off_others_nxt;
  logic                  off_itself_r, off_itself_nxt;

  // one-deep hold so run_end can mark the last action of an item
  logic pend_vld_r, pend_vld_nxt;
  res_t pend_r, pend_nxt;
  logic out_vld_r, out_vld_nxt;
  res_t out_r, out_nxt;
  logic out_end_r, out_end_nxt;

  logic                     in_fire, id_ok, in_id_ok;
  logic [CNT_W-1:0]         old_cnt, new_cnt;
  logic signed [TEMP_W-1:0] eff_t, eff_w, eff_p;
  logic                     warn_hit, trip_hit;
  logic                     cond_ok, out_free, stall;
  logic                     nb_idx, own_idx;
  res_t                     res;

  assign cw      = ucode(pc_r);
  assign in_fire = in_ch.valid && in_ch.ready;
  assign in_ch.ready = (cw.seq == Q_IDLE);

  assign in_id_ok = (in_ch.sensor_id != '0) && (in_ch.sensor_id <= ID_LAST);
  assign rd_addr  = in_id_ok ? ADDR_W'(in_ch.sensor_id - 7'd1) : '0;
  assign id_ok    = (id_r != '0) && (id_r <= ID_LAST);
  assign addr     = id_ok ? ADDR_W'(id_r - 7'd1) : '0;

  // counter update
  assign old_cnt = cnt_vld_r[addr] ? rd_cnt_r : '0;
  always_comb begin
    case (status_r)
      ST_OK:     new_cnt = '0;
      ST_IO_ERR: new_cnt = (old_cnt == CNT_MAX) ? CNT_MAX : old_cnt + 5'd1;
      default:   new_cnt = old_cnt;
    endcase
  end

  // a reading that is not ok compares as zero against zero
  assign eff_t    = (status_r == ST_OK) ? temp_r : '0;
  assign eff_w    = (status_r == ST_OK) ? warn_r : '0;
  assign eff_p    = (status_r == ST_OK) ? trip_r : '0;
  assign warn_hit = id_ok && (eff_t > eff_w);
  assign trip_hit = id_ok && (eff_t > eff_p);

  assign own_idx = own_slot_r[0];
  assign nb_idx  = ~own_slot_r[0];

  always_comb begin
    case (cw.cond)
      C_WARN:     cond_ok = warn_hit;
      C_LINE_HOT: cond_ok = line_hot_r[cw.lc];
      C_FAB_NB:   cond_ok = fabric_hot_r[nb_idx];
      C_FAB_OWN:  cond_ok = fabric_hot_r[own_idx];
      C_OTHERS:   cond_ok = off_others_r;
      C_ITSELF:   cond_ok = off_itself_r;
      default:    cond_ok = 1'b0;
    endcase
  end

  // action word from the control word
  always_comb begin
    res.action = cw.act;
    res.unit   = cw.unit;
    res.cause  = cw.cause;
    case (cw.tsel)
      T_SENSOR: res.target = id_r;
      T_LC: begin
        res.target = ID_W'(cw.lc);
        // low line slots are local to fabric slots 0 and 1
        res.action = ((!cw.lc[LC_W-1]) == (!own_slot_r[1])) ? ACT_LC_LOCAL
                                                             : ACT_LC_REMOTE;
      end
      T_FC_NB:    res.target = ID_W'({own_slot_r[1], nb_idx});
      T_OWN_SLOT: res.target = ID_W'(own_slot_r);
      default:    res.target = id_r;
    endcase
  end

  assign out_free = !out_vld_r || out_ch.ready;
  assign stall    = pend_vld_r && !out_free &&
                    (cond_ok || (cw.seq == Q_FINISH));
  assign mem_we   = (cw.seq == Q_UPDATE) && id_ok;

  always_comb begin
    pc_nxt         = pc_r;
    line_hot_nxt   = line_hot_r;
    fabric_hot_nxt = fabric_hot_r;
    off_others_nxt = off_others_r;
    off_itself_nxt = off_itself_r;
    pend_vld_nxt   = pend_vld_r;
    pend_nxt       = pend_r;
    out_vld_nxt    = out_vld_r && !out_ch.ready;
    out_nxt        = out_r;
    out_end_nxt    = out_end_r;

    if (!stall) begin
      case (cw.seq)
        Q_IDLE:   pc_nxt = (in_fire && enable_r) ? PC_UPD : PC_IDLE;
        Q_UPDATE: pc_nxt = end_r ? PC_HOT_LC : PC_FIN;
        Q_FINISH: pc_nxt = PC_IDLE;
        default:  pc_nxt = pc_r + 5'd1;
      endcase

      if (cw.seq == Q_UPDATE && id_ok) begin
        if (trip_hit) begin
          if (is_line(id_r)) line_hot_nxt[lc_of(id_r)] = 1'b1;
          else               fabric_hot_nxt[fab_idx_of(id_r)] = 1'b1;
        end
        if (new_cnt != '0) begin
          if (new_cnt == retry_r)
            off_others_nxt = 1'b1;
          else if (new_cnt > retry_r && new_cnt >= self_off_r)
            off_itself_nxt = 1'b1;
        end
      end

      if (cond_ok) begin
        if (pend_vld_r) begin
          out_vld_nxt = 1'b1;
          out_nxt     = pend_r;
          out_end_nxt = 1'b0;
        end
        pend_vld_nxt = 1'b1;
        pend_nxt     = res;
      end

      if (cw.seq == Q_FINISH) begin
        if (pend_vld_r) begin
          out_vld_nxt  = 1'b1;
          out_nxt      = pend_r;
          out_end_nxt  = 1'b1;
          pend_vld_nxt = 1'b0;
        end
        if (end_r) begin
          line_hot_nxt   = '0;
          fabric_hot_nxt = '0;
          off_others_nxt = 1'b0;
          off_itself_nxt = 1'b0;
        end
      end
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r         <= PC_IDLE;
      line_hot_r   <= '0;
      fabric_hot_r <= '0;
      off_others_r <= 1'b0;
      off_itself_r <= 1'b0;
      pend_vld_r   <= 1'b0;
      out_vld_r    <= 1'b0;
      cnt_vld_r    <= '0;
    end else begin
      pc_r         <= pc_nxt;
      line_hot_r   <= line_hot_nxt;
      fabric_hot_r <= fabric_hot_nxt;
      off_others_r <= off_others_nxt;
      off_itself_r <= off_itself_nxt;
      pend_vld_r   <= pend_vld_nxt;
      out_vld_r    <= out_vld_nxt;
      if (mem_we) cnt_vld_r[addr] <= 1'b1;
    end
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enable_r   <= 1'b1;
      own_slot_r <= 2'd0;
      retry_r    <= 5'd2;
      self_off_r <= 5'd20;
    end else if (cfg_we) begin
      case (reg_idx_t'(cfg_index))
        REG_ENABLE:   enable_r   <= cfg_wdata[0];
        REG_OWN_SLOT: own_slot_r <= cfg_wdata[1:0];
        REG_RETRY:    retry_r    <= cfg_wdata[CNT_W-1:0];
        REG_SELF_OFF: self_off_r <= cfg_wdata[CNT_W-1:0];
        default:      enable_r   <= enable_r;
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    pend_r    <= pend_nxt;
    out_r     <= out_nxt;
    out_end_r <= out_end_nxt;
    if (in_fire) begin
      id_r     <= in_ch.sensor_id;
      temp_r   <= in_ch.temperature;
      warn_r   <= in_ch.warn_level;
      trip_r   <= in_ch.trip_level;
      status_r <= in_ch.read_status;
      end_r    <= in_ch.scan_end;
    end
  end

  // counter memory: registered read at accept, write on update
  always_ff @(posedge clk) begin
    if (mem_we) cnt_mem[addr] <= new_cnt;
    if (in_fire) rd_cnt_r <= cnt_mem[rd_addr];
  end

  assign out_ch.valid   = out_vld_r;
  assign out_ch.action  = out_r.action;
  assign out_ch.target  = out_r.target;
  assign out_ch.unit    = out_r.unit;
  assign out_ch.cause   = out_r.cause;
  assign out_ch.run_end = out_end_r;

endmodule

[rtl/ctss_sva.sv]
// ----------------------------------------------------------------------------
// ctss_sva
// Port-level checks on the supervisor's action channel.
// ----------------------------------------------------------------------------
`include "chassis_thermal_shutdown_supervisor_defines.svh"

module ctss_sva (
  input logic                      clk,
  input logic                      rst_n,
  input logic                      out_valid,
  input logic                      out_ready,
  input logic [2:0]                out_action,
  input logic [ctss_pkg::ID_W-1:0] out_target,
  input logic                      out_unit,
  input logic                      out_cause,
  input logic                      out_run_end
);
  import ctss_pkg::*;

  `CTSS_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_action) && $stable(out_target) && $stable(out_unit) && $stable(out_cause) && $stable(out_run_end), "stalled action changed")

  `CTSS_ASSERT_NOW(a_warn_form, clk, rst_n, out_valid && out_action == ACT_WARN, !out_cause && !out_unit && out_target != '0 && out_target <= ID_LAST, "bad warning")

  `CTSS_ASSERT_NOW(a_reset_form, clk, rst_n, out_valid && (out_action == ACT_MAC_RESET || out_action == ACT_CPU_RESET), out_cause && out_target <= 7'd3, "bad reset action")

  `CTSS_ASSERT_NOW(a_unit_use, clk, rst_n, out_valid && out_unit, out_action == ACT_MAC_RESET || out_action == ACT_CPU_RESET, "unit set on wrong action")

endmodule

bind chassis_thermal_shutdown_supervisor ctss_sva u_ctss_sva (
  .clk         (clk),
  .rst_n       (rst_n),
  .out_valid   (out_ch.valid),
  .out_ready   (out_ch.ready),
  .out_action  (out_ch.action),
  .out_target  (out_ch.target),
  .out_unit    (out_ch.unit),
  .out_cause   (out_ch.cause),
  .out_run_end (out_ch.run_end)
);
